// ===== sv/tdf_pkg.sv =====
// Shared types and constants for the tetrahedral deformation / fibre target block.
// No dependencies; used by the channel interfaces, the multiplier unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

  // Fixed widths of the channel fields
  localparam int FIELD_BITS = 32;
  localparam int SLOT_BITS  = 5;
  localparam int IDX_BITS   = 4;

  localparam logic signed [FIELD_BITS-1:0] FIELD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_BITS-1:0] FIELD_MIN = 32'sh8000_0000;

  // Operand slot map
  localparam int NUM_SLOTS = 25;
  localparam logic [SLOT_BITS-1:0] SLOT_LIMIT = 5'd25;
  localparam logic [SLOT_BITS-1:0] SLOT_INVDM = 5'd12;
  localparam logic [SLOT_BITS-1:0] SLOT_FIBER = 5'd21;
  localparam logic [SLOT_BITS-1:0] SLOT_ACT   = 5'd24;

  // Result index map
  localparam int NUM_GRAD = 9;
  localparam logic [IDX_BITS-1:0] IDX_P0   = 4'd9;
  localparam logic [IDX_BITS-1:0] IDX_LAST = 4'd11;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DS_BASE,
    ST_DS_SUB,
    ST_F_MUL,
    ST_F_WAIT,
    ST_F_OUT,
    ST_T,
    ST_G_MUL,
    ST_G_WAIT,
    ST_H_MUL,
    ST_H_WAIT,
    ST_P_OUT
  } seq_state_t;

  // Multiplier unit states
  typedef enum logic [1:0] {
    MS_IDLE,
    MS_LO,
    MS_HI,
    MS_SAT
  } mul_state_t;

  // Status returned by the multiplier unit
  typedef struct packed {
    logic busy;
    logic done;
    logic ov;
  } mul_stat_t;

endpackage

`default_nettype wire

// ===== sv/tdf_in_if.sv =====
// Operand request channel: valid/ready handshake with slot, value and start flag.
// Depends on tdf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [tdf_pkg::SLOT_BITS-1:0]         operand_slot;
  logic signed [tdf_pkg::FIELD_BITS-1:0] operand_value;
  logic                                  start_req;

  modport source (
    output valid, operand_slot, operand_value, start_req,
    input  ready
  );

  modport sink (
    input  valid, operand_slot, operand_value, start_req,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/tdf_out_if.sv =====
// Result request channel: valid/ready handshake with index, value and flags.
// Depends on tdf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tdf_pkg::IDX_BITS-1:0]          result_index;
  logic signed [tdf_pkg::FIELD_BITS-1:0] result_value;
  logic                                  overflow;
  logic                                  last_result;

  modport source (
    output valid, result_index, result_value, overflow, last_result,
    input  ready
  );

  modport sink (
    input  valid, result_index, result_value, overflow, last_result,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/tdf_mulq.sv =====
// Shared fixed-point multiplier: two half-width partial products, then floor shift
// and saturation. Depends on tdf_pkg (mul_state_t, mul_stat_t).
`timescale 1ns / 1ps
`default_nettype none

module tdf_mulq #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire logic signed [WORD_BITS-1:0] a,
  input  wire logic signed [WORD_BITS-1:0] b,
  output logic signed [WORD_BITS-1:0]  res,
  output tdf_pkg::mul_stat_t           stat
);

  localparam int LO = WORD_BITS / 2;          // low half of b
  localparam int MB = WORD_BITS - LO + 1;     // signed multiplier operand width
  localparam int PW = 2 * WORD_BITS;          // exact product width

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  tdf_pkg::mul_state_t state, state_next;

  logic signed [WORD_BITS-1:0]    ra, rb;
  logic signed [PW-1:0]           pacc;
  logic signed [MB-1:0]           bsel;
  logic signed [WORD_BITS+MB-1:0] prod;
  logic signed [PW-1:0]           shifted;
  logic                           fits;
  logic signed [WORD_BITS-1:0]    sat_val;
  logic                           done, ov;

  // Operand half select: low half zero-extended, high half sign-extended
  always_comb begin
    if (state == tdf_pkg::MS_LO) begin
      bsel = $signed(MB'(rb[LO-1:0]));
    end else begin
      bsel = MB'($signed(rb[WORD_BITS-1:LO]));
    end
  end

  assign prod = ra * bsel;

  // Floor shift and saturation of the exact product
  assign shifted = pacc >>> FRAC_BITS;
  assign fits    = (&shifted[PW-1:WORD_BITS-1]) | ~(|shifted[PW-1:WORD_BITS-1]);
  assign sat_val = fits ? shifted[WORD_BITS-1:0] : (shifted[PW-1] ? WMIN : WMAX);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tdf_pkg::MS_IDLE: if (start) state_next = tdf_pkg::MS_LO;
      tdf_pkg::MS_LO:   state_next = tdf_pkg::MS_HI;
      tdf_pkg::MS_HI:   state_next = tdf_pkg::MS_SAT;
      tdf_pkg::MS_SAT:  state_next = tdf_pkg::MS_IDLE;
      default:          state_next = tdf_pkg::MS_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      ov   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        tdf_pkg::MS_IDLE: begin
          if (start) begin
            ra <= a;
            rb <= b;
          end
        end
        tdf_pkg::MS_LO: pacc <= PW'(prod);
        tdf_pkg::MS_HI: pacc <= pacc + (PW'(prod) <<< LO);
        tdf_pkg::MS_SAT: begin
          res  <= sat_val;
          ov   <= ~fits;
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (state != tdf_pkg::MS_IDLE);
  assign stat.done = done;
  assign stat.ov   = ov;

endmodule

`default_nettype wire

// ===== sv/tet_deformation_fiber_target_core.sv =====
// Load: one operand request per cycle while idle. Start: the edge matrix, then 45 products
// on the shared multiplier and 12 result loads up to the last result, plus any output
// stall; not ready during that run.
// Reset clears the operand store, sequencer and output valid flag.
// Depends on tdf_pkg, tdf_in_if, tdf_out_if and tdf_mulq.
`timescale 1ns / 1ps
`default_nettype none

module tet_deformation_fiber_target_core #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire     clk,
  input  wire     rst,
  tdf_in_if.sink  operand,
  tdf_out_if.source result
);

  localparam int FB = tdf_pkg::FIELD_BITS;
  localparam int AW = WORD_BITS + 2;                              // three-term sum
  localparam int IW = (WORD_BITS > FB) ? WORD_BITS : FB;          // load / emit width
  localparam int TW = ((WORD_BITS > FRAC_BITS + 1) ? WORD_BITS : FRAC_BITS + 1) + 1;

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  tdf_pkg::seq_state_t state, state_next;

  // Stores
  logic signed [WORD_BITS-1:0] opnd [tdf_pkg::NUM_SLOTS];
  logic signed [WORD_BITS-1:0] ds   [tdf_pkg::NUM_GRAD];
  logic signed [WORD_BITS-1:0] grad [tdf_pkg::NUM_GRAD];
  logic signed [WORD_BITS-1:0] g    [3];

  // Counters and flags
  logic [1:0] ri, cj, kk;
  logic [2:0] rowov;
  logic       tov, pov, fov;

  logic signed [WORD_BITS-1:0] base, t, pres;
  logic signed [AW-1:0]        acc;

  // Output register
  logic                         out_valid;
  logic [tdf_pkg::IDX_BITS-1:0] out_index;
  logic signed [FB-1:0]         out_value;
  logic                         out_ov, out_last;

  // Control
  logic                          in_acc, out_free, out_load, mul_start;
  logic [tdf_pkg::SLOT_BITS-1:0] rd_addr;
  logic signed [WORD_BITS-1:0]   opnd_rd;
  logic [3:0]                    idx9, dsk_idx;
  logic [tdf_pkg::SLOT_BITS-1:0] k3;
  logic                          row_end, grid_end;

  // Multiplier connection
  logic signed [WORD_BITS-1:0] mul_a, mul_b, mul_res;
  tdf_pkg::mul_stat_t          mstat;

  tdf_mulq #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_mulq (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res),
    .stat  (mstat)
  );

  assign in_acc   = operand.valid && operand.ready;
  assign out_free = !out_valid || result.ready;
  assign operand.ready = (state == tdf_pkg::ST_IDLE);

  assign idx9     = {1'b0, ri, 1'b0} + {2'b0, ri} + {2'b0, cj};
  assign dsk_idx  = {1'b0, ri, 1'b0} + {2'b0, ri} + {2'b0, kk};
  assign k3       = {2'b0, kk, 1'b0} + {3'b0, kk};
  assign row_end  = (cj == 2'd2);
  assign grid_end = (cj == 2'd2) && (ri == 2'd2);
  assign opnd_rd  = opnd[rd_addr];

  // Load saturation to the word range
  logic signed [IW-1:0]        ld_ext;
  logic                        ld_fit;
  logic signed [WORD_BITS-1:0] ld_val;
  assign ld_ext = IW'(operand.operand_value);
  assign ld_fit = (&ld_ext[IW-1:WORD_BITS-1]) | ~(|ld_ext[IW-1:WORD_BITS-1]);
  assign ld_val = ld_fit ? WORD_BITS'(ld_ext) : (ld_ext[IW-1] ? WMIN : WMAX);

  // Edge difference
  logic signed [WORD_BITS:0]   dif;
  logic                        dif_ov;
  logic signed [WORD_BITS-1:0] dif_val;
  assign dif     = (WORD_BITS+1)'(opnd_rd) - (WORD_BITS+1)'(base);
  assign dif_ov  = dif[WORD_BITS] != dif[WORD_BITS-1];
  assign dif_val = dif_ov ? (dif[WORD_BITS] ? WMIN : WMAX) : dif[WORD_BITS-1:0];

  // Accumulate and saturate
  logic signed [AW-1:0]        sum;
  logic                        sum_ov;
  logic signed [WORD_BITS-1:0] sum_val;
  assign sum     = acc + AW'(mul_res);
  assign sum_ov  = ~((&sum[AW-1:WORD_BITS-1]) | ~(|sum[AW-1:WORD_BITS-1]));
  assign sum_val = sum_ov ? (sum[AW-1] ? WMIN : WMAX) : sum[WORD_BITS-1:0];

  // Scale factor 1 - activation
  logic signed [TW-1:0]        tdif;
  logic                        t_ov;
  logic signed [WORD_BITS-1:0] t_val;
  assign tdif  = (TW'(1) <<< FRAC_BITS) - TW'(opnd_rd);
  assign t_ov  = ~((&tdif[TW-1:WORD_BITS-1]) | ~(|tdif[TW-1:WORD_BITS-1]));
  assign t_val = t_ov ? (tdif[TW-1] ? WMIN : WMAX) : tdif[WORD_BITS-1:0];

  // Emit: narrow to the 32-bit field
  logic signed [WORD_BITS-1:0] em_src;
  logic signed [IW-1:0]        em_ext;
  logic                        em_fit;
  logic signed [FB-1:0]        em_val;
  assign em_src = (state == tdf_pkg::ST_F_OUT) ? grad[idx9] : pres;
  assign em_ext = IW'(em_src);
  assign em_fit = (&em_ext[IW-1:FB-1]) | ~(|em_ext[IW-1:FB-1]);
  assign em_val = em_fit ? FB'(em_ext)
                         : (em_ext[IW-1] ? tdf_pkg::FIELD_MIN : tdf_pkg::FIELD_MAX);

  // Multiplier operand select
  always_comb begin
    case (state)
      tdf_pkg::ST_F_MUL: begin
        mul_a = ds[dsk_idx];
        mul_b = opnd_rd;
      end
      tdf_pkg::ST_G_MUL: begin
        mul_a = t;
        mul_b = grad[idx9];
      end
      default: begin
        mul_a = g[cj];
        mul_b = opnd_rd;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    out_load   = 1'b0;
    rd_addr    = {3'b0, ri};
    case (state)
      tdf_pkg::ST_IDLE: begin
        if (in_acc && operand.start_req) state_next = tdf_pkg::ST_DS_BASE;
      end
      tdf_pkg::ST_DS_BASE: begin
        rd_addr    = {3'b0, ri};
        state_next = tdf_pkg::ST_DS_SUB;
      end
      tdf_pkg::ST_DS_SUB: begin
        rd_addr    = {2'b0, cj, 1'b0} + {3'b0, cj} + 5'd3 + {3'b0, ri};
        state_next = grid_end ? tdf_pkg::ST_F_MUL : tdf_pkg::ST_DS_BASE;
      end
      tdf_pkg::ST_F_MUL: begin
        rd_addr    = tdf_pkg::SLOT_INVDM + k3 + {3'b0, cj};
        mul_start  = 1'b1;
        state_next = tdf_pkg::ST_F_WAIT;
      end
      tdf_pkg::ST_F_WAIT: begin
        if (mstat.done) begin
          state_next = (kk == 2'd2 && grid_end) ? tdf_pkg::ST_F_OUT : tdf_pkg::ST_F_MUL;
        end
      end
      tdf_pkg::ST_F_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (grid_end) state_next = tdf_pkg::ST_T;
        end
      end
      tdf_pkg::ST_T: begin
        rd_addr    = tdf_pkg::SLOT_ACT;
        state_next = tdf_pkg::ST_G_MUL;
      end
      tdf_pkg::ST_G_MUL: begin
        mul_start  = 1'b1;
        state_next = tdf_pkg::ST_G_WAIT;
      end
      tdf_pkg::ST_G_WAIT: begin
        if (mstat.done) state_next = row_end ? tdf_pkg::ST_H_MUL : tdf_pkg::ST_G_MUL;
      end
      tdf_pkg::ST_H_MUL: begin
        rd_addr    = tdf_pkg::SLOT_FIBER + {3'b0, cj};
        mul_start  = 1'b1;
        state_next = tdf_pkg::ST_H_WAIT;
      end
      tdf_pkg::ST_H_WAIT: begin
        rd_addr = tdf_pkg::SLOT_FIBER + {3'b0, cj};
        if (mstat.done) state_next = row_end ? tdf_pkg::ST_P_OUT : tdf_pkg::ST_H_MUL;
      end
      tdf_pkg::ST_P_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (ri == 2'd2) ? tdf_pkg::ST_IDLE : tdf_pkg::ST_G_MUL;
        end
      end
      default: state_next = tdf_pkg::ST_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_value <= em_val;
        if (state == tdf_pkg::ST_F_OUT) begin
          out_index <= idx9;
          out_ov    <= rowov[ri] | ~em_fit;
          out_last  <= 1'b0;
        end else begin
          out_index <= tdf_pkg::IDX_P0 + {2'b0, ri};
          out_ov    <= rowov[ri] | tov | pov | ~em_fit;
          out_last  <= (ri == 2'd2);
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.result_index = out_index;
  assign result.result_value = out_value;
  assign result.overflow     = out_ov;
  assign result.last_result  = out_last;

  // Operand store, counters and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < tdf_pkg::NUM_SLOTS; n++) opnd[n] <= '0;
      ri    <= '0;
      cj    <= '0;
      kk    <= '0;
      rowov <= '0;
      tov   <= 1'b0;
      pov   <= 1'b0;
      fov   <= 1'b0;
      acc   <= '0;
    end else begin
      case (state)
        tdf_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (operand.operand_slot < tdf_pkg::SLOT_LIMIT) begin
              opnd[operand.operand_slot] <= ld_val;
            end
            if (operand.start_req) begin
              ri    <= '0;
              cj    <= '0;
              kk    <= '0;
              rowov <= '0;
              acc   <= '0;
              fov   <= 1'b0;
            end
          end
        end
        tdf_pkg::ST_DS_BASE: base <= opnd_rd;
        tdf_pkg::ST_DS_SUB: begin
          ds[idx9] <= dif_val;
          if (dif_ov) rowov[ri] <= 1'b1;
          if (row_end) begin
            cj <= '0;
            ri <= (ri == 2'd2) ? 2'd0 : ri + 2'd1;
          end else begin
            cj <= cj + 2'd1;
          end
        end
        tdf_pkg::ST_F_WAIT: begin
          if (mstat.done) begin
            if (kk == 2'd2) begin
              grad[idx9] <= sum_val;
              if (fov | mstat.ov | sum_ov) rowov[ri] <= 1'b1;
              acc <= '0;
              fov <= 1'b0;
              kk  <= '0;
              if (row_end) begin
                cj <= '0;
                ri <= (ri == 2'd2) ? 2'd0 : ri + 2'd1;
              end else begin
                cj <= cj + 2'd1;
              end
            end else begin
              acc <= sum;
              fov <= fov | mstat.ov;
              kk  <= kk + 2'd1;
            end
          end
        end
        tdf_pkg::ST_F_OUT: begin
          if (out_free) begin
            if (row_end) begin
              cj <= '0;
              ri <= (ri == 2'd2) ? 2'd0 : ri + 2'd1;
            end else begin
              cj <= cj + 2'd1;
            end
          end
        end
        tdf_pkg::ST_T: begin
          t   <= t_val;
          tov <= t_ov;
          pov <= 1'b0;
          acc <= '0;
        end
        tdf_pkg::ST_G_WAIT: begin
          if (mstat.done) begin
            g[cj] <= mul_res;
            pov   <= pov | mstat.ov;
            cj    <= row_end ? 2'd0 : cj + 2'd1;
          end
        end
        tdf_pkg::ST_H_WAIT: begin
          if (mstat.done) begin
            if (row_end) begin
              pres <= sum_val;
              pov  <= pov | mstat.ov | sum_ov;
              acc  <= '0;
              cj   <= '0;
            end else begin
              acc <= sum;
              pov <= pov | mstat.ov;
              cj  <= cj + 2'd1;
            end
          end
        end
        tdf_pkg::ST_P_OUT: begin
          if (out_free) begin
            ri  <= (ri == 2'd2) ? 2'd0 : ri + 2'd1;
            pov <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mstat.busy)
    else $error("multiplier started while busy");

  a_accept_unit_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> !mstat.busy)
    else $error("operand request accepted while multiplier busy");

  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_acc && operand.start_req) |=> !operand.ready)
    else $error("ready held after start request");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_result) |-> (result.result_index == tdf_pkg::IDX_LAST))
    else $error("last result flag on wrong index");

endmodule

`default_nettype wire

// ===== dv/tet_deformation_fiber_target_core_test.sv =====
// Self-checking bench for the tetrahedral deformation gradient / fibre target core.
// Uses tdf_pkg, tdf_in_if and tdf_out_if; drives operand requests, checks every result request.
`timescale 1ns / 1ps

localparam int     Q_FRAC  = 16;
localparam longint WORD_HI = 64'sd2147483647;
localparam longint WORD_LO = -64'sd2147483648;
localparam logic signed [tdf_pkg::FIELD_BITS-1:0] Q_ONE  = 32'sh0001_0000;
localparam logic signed [tdf_pkg::FIELD_BITS-1:0] Q_HALF = 32'sh0000_8000;

typedef struct {
  logic [tdf_pkg::IDX_BITS-1:0]          index;
  logic signed [tdf_pkg::FIELD_BITS-1:0] value;
  logic                                  ovf;
  logic                                  last;
} fdg_result_t;

// Keeps its own copy of the operand and gradient stores and the queue of results due
class element_checker;
  longint      operand_store[tdf_pkg::NUM_SLOTS];
  longint      gradient_store[tdf_pkg::NUM_GRAD];
  fdg_result_t gradient_queue[$];
  int          errors;

  function new();
    foreach (operand_store[i]) operand_store[i] = 0;
    foreach (gradient_store[i]) gradient_store[i] = 0;
    errors = 0;
  endfunction

  function longint clamp(longint v, inout bit ov);
    if (v > WORD_HI) begin
      ov = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      ov = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  // floor(a*b / 2^frac); operands are always within the word, so 64 bits hold the product
  function longint qmul(longint a, longint b, inout bit ov);
    longint p;
    p = a * b;
    return clamp(p >>> Q_FRAC, ov);
  endfunction

  function void push_result(int idx, longint v, bit ov);
    fdg_result_t r;
    r.index = tdf_pkg::IDX_BITS'(idx);
    r.value = v[tdf_pkg::FIELD_BITS-1:0];
    r.ovf   = ov;
    r.last  = (r.index == tdf_pkg::IDX_LAST);
    gradient_queue = {gradient_queue, r};
  endfunction

  // F = Ds * invDm, then p0 = ((1 - act) * F) * fibre
  function void form_gradient_and_target();
    bit     row_ov[3];
    bit     ov;
    bit     scale_ov;
    longint ds[3][3];
    longint g[3];
    longint acc;
    longint scale;
    for (int i = 0; i < 3; i++) begin
      row_ov[i] = 1'b0;
      for (int j = 0; j < 3; j++)
        ds[i][j] = clamp(operand_store[3 * (j + 1) + i] - operand_store[i], row_ov[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ov  = 1'b0;
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += qmul(ds[i][k], operand_store[int'(tdf_pkg::SLOT_INVDM) + 3 * k + j], ov);
        gradient_store[3 * i + j] = clamp(acc, ov);
        if (ov) row_ov[i] = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        push_result(3 * i + j, gradient_store[3 * i + j], row_ov[i]);

    scale_ov = 1'b0;
    scale    = clamp((longint'(1) << Q_FRAC) - operand_store[tdf_pkg::SLOT_ACT], scale_ov);
    for (int i = 0; i < 3; i++) begin
      ov  = row_ov[i] | scale_ov;
      acc = 0;
      for (int j = 0; j < 3; j++)
        g[j] = qmul(scale, gradient_store[3 * i + j], ov);
      for (int j = 0; j < 3; j++)
        acc += qmul(g[j], operand_store[int'(tdf_pkg::SLOT_FIBER) + j], ov);
      acc = clamp(acc, ov);
      push_result(int'(tdf_pkg::IDX_P0) + i, acc, ov);
    end
  endfunction

  function void note_request(logic [tdf_pkg::SLOT_BITS-1:0] slot,
                             logic signed [tdf_pkg::FIELD_BITS-1:0] value, bit start);
    if (slot < tdf_pkg::SLOT_LIMIT) operand_store[slot] = value;
    if (start) form_gradient_and_target();
  endfunction

  function int pending();
    return gradient_queue.size();
  endfunction

  function void check_result(logic [tdf_pkg::IDX_BITS-1:0] idx,
                             logic signed [tdf_pkg::FIELD_BITS-1:0] value,
                             logic ovf, logic last);
    fdg_result_t e;
    if (gradient_queue.size() == 0) begin
      $display("%0t: result with none due: index %0d value %h", $time, idx, value);
      errors++;
      return;
    end
    e = gradient_queue.pop_front();
    if (idx !== e.index) begin
      $display("%0t: result_index expected %0d actual %0d", $time, e.index, idx);
      errors++;
    end
    if (value !== e.value) begin
      $display("%0t: result_value (index %0d) expected %h actual %h", $time, e.index,
               e.value, value);
      errors++;
    end
    if (ovf !== e.ovf) begin
      $display("%0t: overflow (index %0d) expected %b actual %b", $time, e.index, e.ovf, ovf);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: last_result (index %0d) expected %b actual %b", $time, e.index,
               e.last, last);
      errors++;
    end
  endfunction
endclass

module tet_deformation_fiber_target_core_test;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  element_checker sb = new();

  tdf_in_if  op_ch();
  tdf_out_if res_ch();

  tet_deformation_fiber_target_core uut (
    .clk     (clk),
    .rst     (rst),
    .operand (op_ch),
    .result  (res_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tet_deformation_fiber_target_core_test: FAIL");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else begin
        res_ch.ready = !rst && ($urandom_range(99, 0) >= recv_idle);
      end
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (!rst && res_ch.valid === 1'b1 && res_ch.ready)
        sb.check_result(res_ch.result_index, res_ch.result_value, res_ch.overflow,
                        res_ch.last_result);
    end
  end

  function automatic logic [tdf_pkg::SLOT_BITS-1:0] corner_slot(int corner, int axis);
    return tdf_pkg::SLOT_BITS'(3 * corner + axis);
  endfunction

  // Operand values: moderate Q16.16 numbers, raw random words or edge values
  function automatic logic signed [tdf_pkg::FIELD_BITS-1:0] pick_value(int style, int slot);
    int v;
    int mode;
    mode = style;
    if (style == 2) mode = $urandom_range(3, 0);
    case (mode)
      0: begin
        if (slot < int'(tdf_pkg::SLOT_INVDM))
          v = int'($urandom_range(32'h80000, 0)) - 32'h40000;
        else if (slot < int'(tdf_pkg::SLOT_FIBER))
          v = int'($urandom_range(32'h40000, 0)) - 32'h20000;
        else if (slot < int'(tdf_pkg::SLOT_ACT))
          v = int'($urandom_range(32'h20000, 0)) - 32'h10000;
        else
          v = int'($urandom_range(32'h12000, 0));
      end
      1: v = $urandom;
      default: begin
        case ($urandom_range(5, 0))
          0: v = tdf_pkg::FIELD_MAX;
          1: v = tdf_pkg::FIELD_MIN;
          2: v = 0;
          3: v = Q_ONE;
          4: v = -Q_ONE;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_item(input logic [tdf_pkg::SLOT_BITS-1:0] slot,
                           input logic signed [tdf_pkg::FIELD_BITS-1:0] value,
                           input bit start);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle) begin
      op_ch.valid = 1'b0;
      @(negedge clk);
    end
    op_ch.valid         = 1'b1;
    op_ch.operand_slot  = slot;
    op_ch.operand_value = value;
    op_ch.start_req     = start;
    do @(posedge clk); while (!op_ch.ready);
    sb.note_request(slot, value, start);
  endtask

  // Sender stops and waits for every result due
  task automatic drain();
    @(negedge clk);
    op_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    // start straight from the cleared store
    send_item(corner_slot(0, 0), 0, 1'b1);
    // unit tetrahedron, identity rest inverse, half activation
    send_item(corner_slot(1, 0), Q_ONE, 1'b0);
    send_item(corner_slot(2, 1), Q_ONE, 1'b0);
    send_item(corner_slot(3, 2), Q_ONE, 1'b0);
    send_item(tdf_pkg::SLOT_INVDM, Q_ONE, 1'b0);
    send_item(tdf_pkg::SLOT_INVDM + 5'd4, Q_ONE, 1'b0);
    send_item(tdf_pkg::SLOT_INVDM + 5'd8, Q_ONE, 1'b0);
    send_item(tdf_pkg::SLOT_FIBER, Q_ONE, 1'b0);
    send_item(tdf_pkg::SLOT_ACT, Q_HALF, 1'b1);
    // tiny negative factor: truncation rounds towards minus infinity
    send_item(tdf_pkg::SLOT_INVDM, -1, 1'b1);
    // scale factor saturates
    send_item(tdf_pkg::SLOT_ACT, tdf_pkg::FIELD_MIN, 1'b1);
    // edge differences saturate
    send_item(corner_slot(0, 0), tdf_pkg::FIELD_MIN, 1'b1);
    send_item(corner_slot(1, 0), tdf_pkg::FIELD_MAX, 1'b1);
    send_item(tdf_pkg::SLOT_FIBER, tdf_pkg::FIELD_MAX, 1'b0);
    send_item(tdf_pkg::SLOT_FIBER + 5'd1, tdf_pkg::FIELD_MIN, 1'b1);
    // out-of-range slots store nothing but still start
    send_item(tdf_pkg::SLOT_LIMIT, $urandom, 1'b1);
    send_item(5'd31, 32'shFFFF_FFFF, 1'b0);
    send_item(tdf_pkg::SLOT_LIMIT + 5'd5, tdf_pkg::FIELD_MAX, 1'b1);
    // activation extremes
    send_item(tdf_pkg::SLOT_ACT, 0, 1'b0);
    send_item(tdf_pkg::SLOT_ACT, tdf_pkg::FIELD_MAX, 1'b1);
    send_item(corner_slot(0, 0), 0, 1'b0);
    send_item(corner_slot(1, 0), Q_ONE, 1'b1);
  endtask

  // Mostly whole elements with random content, mixed with partial reloads, noise and broken loads
  task automatic run_random(input int n);
    int count;
    int kind;
    int style;
    int m;
    int j;
    int tmp;
    int order[tdf_pkg::NUM_SLOTS];
    count = 0;
    while (count < n) begin
      kind  = $urandom_range(19, 0);
      style = $urandom_range(99, 0) < 60 ? 0 : ($urandom_range(1, 0) ? 1 : 2);
      if (kind < 12) begin
        for (int i = 0; i < tdf_pkg::NUM_SLOTS; i++) order[i] = i;
        if ($urandom_range(1, 0)) begin
          for (int i = tdf_pkg::NUM_SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
        end
        for (int i = 0; i < tdf_pkg::NUM_SLOTS; i++)
          send_item(tdf_pkg::SLOT_BITS'(order[i]), pick_value(style, order[i]),
                    i == tdf_pkg::NUM_SLOTS - 1);
        count += tdf_pkg::NUM_SLOTS;
      end else if (kind < 16) begin
        m = $urandom_range(6, 1);
        for (int i = 0; i < m; i++) begin
          j = $urandom_range(tdf_pkg::NUM_SLOTS - 1, 0);
          send_item(tdf_pkg::SLOT_BITS'(j), pick_value(style, j), i == m - 1);
        end
        count += m;
      end else if (kind < 18) begin
        m = $urandom_range(8, 1);
        for (int i = 0; i < m; i++)
          send_item(tdf_pkg::SLOT_BITS'($urandom_range(31, 0)), $urandom,
                    $urandom_range(7, 0) == 0);
        count += m;
      end else begin
        // load cut short, then a start from a slot that stores nothing
        m = $urandom_range(12, 1);
        for (int i = 0; i < m; i++) begin
          j = $urandom_range(tdf_pkg::NUM_SLOTS - 1, 0);
          send_item(tdf_pkg::SLOT_BITS'(j), pick_value(style, j), 1'b0);
        end
        send_item(tdf_pkg::SLOT_BITS'($urandom_range(31, int'(tdf_pkg::SLOT_LIMIT))),
                  $urandom, 1'b1);
        count += m + 1;
      end
    end
  endtask

  initial begin
    op_ch.valid         = 1'b0;
    op_ch.operand_slot  = '0;
    op_ch.operand_value = '0;
    op_ch.start_req     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender mostly busy, receiver mostly stalling
    send_idle = 19;
    recv_idle = 75;
    run_directed();
    run_random(110);
    drain();

    // sender mostly idle, receiver mostly ready
    send_idle = 75;
    recv_idle = 19;
    run_random(115);
    drain();

    // no idling; a long receiver hold-off first so the input backs up
    send_idle = 0;
    recv_idle = 0;
    @(negedge clk);
    hold_req = 1'b1;
    run_random(115);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tet_deformation_fiber_target_core_test: PASS");
    end else begin
      $display("tet_deformation_fiber_target_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tdf_pkg.sv
sv/tdf_in_if.sv
sv/tdf_out_if.sv
sv/tdf_mulq.sv
sv/tet_deformation_fiber_target_core.sv
dv/tet_deformation_fiber_target_core_test.sv
